### sv/nmea_sentence_framer_checker_core_defines.svh
// Assertion macros shared by the checker of the NMEA sentence framer.
// No dependencies; each macro expects clk and rst_n in scope.
`ifndef NMEA_SENTENCE_FRAMER_CHECKER_CORE_DEFINES_SVH
`define NMEA_SENTENCE_FRAMER_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define NMEACHK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define NMEACHK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/nmeachk_pkg.sv
// Shared types, character codes and helpers for the NMEA sentence framer.
// No dependencies; used by the framer, the top level and the checker.
`timescale 1ns / 1ps

package nmeachk_pkg;

  // Default length at which a sentence is dropped (one less than this).
  localparam int LINE_BUFFER_BYTES_DEF = 128;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  typedef enum logic [1:0] {
    FS_OK        = 2'd0,
    FS_MISMATCH  = 2'd1,
    FS_MALFORMED = 2'd2
  } frame_status_t;

  // One finished sentence, as handed from the framer to the result register.
  typedef struct packed {
    logic          emit;
    frame_status_t status;
    logic [7:0]    computed_sum;
    logic [7:0]    received_sum;
    logic [6:0]    sentence_length;
  } frame_res_t;

  // Nibble value of a hex digit; bit 4 set when the character is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end
    return v;
  endfunction

endpackage

### sv/nmeachk_frame.sv
// Sentence framing state and checksum evaluation for one byte per step.
// Depends on nmeachk_pkg.
`timescale 1ns / 1ps

module nmeachk_frame #(
  parameter int LINE_BUFFER_BYTES = nmeachk_pkg::LINE_BUFFER_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step_en,
  input  logic [7:0]              rx_byte,
  output nmeachk_pkg::frame_res_t res
);
  import nmeachk_pkg::*;

  localparam int CNT_W = $clog2(LINE_BUFFER_BYTES);
  localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(LINE_BUFFER_BYTES - 1);

  logic             in_sent_r, in_sent_nxt;
  logic             star_r, star_nxt;
  logic             aft_r, aft_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [7:0]       first_r, first_nxt;

  logic [CNT_W-1:0] cnt_inc;
  logic [4:0]       hi_val;
  logic [4:0]       lo_val;
  logic [7:0]       rsum;

  // Decode the two checksum characters; only used on the closing byte.
  always_comb begin
    hi_val = hex_value(first_r);
    lo_val = hex_value(rx_byte);
    rsum   = {hi_val[3:0], lo_val[3:0]};
  end

  assign cnt_inc = cnt_r + CNT_W'(1);

  // Next state of the framer and the result of this byte.
  always_comb begin
    in_sent_nxt = in_sent_r;
    star_nxt    = star_r;
    aft_nxt     = aft_r;
    cnt_nxt     = cnt_r;
    xor_nxt     = xor_r;
    first_nxt   = first_r;

    // The held byte closes a sentence; this does not depend on the step going ahead.
    res.emit            = in_sent_r && star_r && aft_r && (cnt_inc != CNT_LIM);
    res.status          = FS_OK;
    res.computed_sum    = xor_r;
    res.received_sum    = rsum;
    res.sentence_length = 7'(cnt_inc);

    if (hi_val[4] || lo_val[4]) begin
      res.status       = FS_MALFORMED;
      res.received_sum = 8'h00;
    end else if (rsum != xor_r) begin
      res.status = FS_MISMATCH;
    end

    if (step_en) begin
      if (!in_sent_r) begin
        // Waiting for the opening dollar; everything else is ignored.
        if (rx_byte == CH_DOLLAR) begin
          in_sent_nxt = 1'b1;
          cnt_nxt     = CNT_W'(1);
        end
      end else begin
        cnt_nxt = cnt_inc;
        if (cnt_inc == CNT_LIM) begin
          // Too long: drop silently and go back to waiting.
          in_sent_nxt = 1'b0;
          star_nxt    = 1'b0;
          aft_nxt     = 1'b0;
          cnt_nxt     = '0;
          xor_nxt     = 8'h00;
        end else if (!star_r) begin
          if (rx_byte == CH_STAR) begin
            star_nxt = 1'b1;
          end else begin
            xor_nxt = xor_r ^ rx_byte;
          end
        end else if (!aft_r) begin
          first_nxt = rx_byte;
          aft_nxt   = 1'b1;
        end else begin
          // Second checksum character closes the sentence.
          in_sent_nxt = 1'b0;
          star_nxt    = 1'b0;
          aft_nxt     = 1'b0;
          cnt_nxt     = '0;
          xor_nxt     = 8'h00;
        end
      end
    end
  end

  // Framer state; the first checksum character is payload and needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sent_r <= 1'b0;
      star_r    <= 1'b0;
      aft_r     <= 1'b0;
      cnt_r     <= '0;
      xor_r     <= 8'h00;
    end else begin
      in_sent_r <= in_sent_nxt;
      star_r    <= star_nxt;
      aft_r     <= aft_nxt;
      cnt_r     <= cnt_nxt;
      xor_r     <= xor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
  end

endmodule

### sv/nmea_sentence_framer_checker_core.sv
// Top level of the NMEA 0183 sentence framer and checksum checker.
// Depends on nmeachk_pkg and nmeachk_frame.
`timescale 1ns / 1ps
//
// Usage:
// One received character enters per input beat on in_rx_byte (in_valid,
// in_stall). A '$' opens a sentence; the bytes up to the first '*' are XORed,
// and the two characters after that star are the received checksum. On the
// second of them one result beat leaves on the out_ channel with the status
// (ok, mismatch or malformed), both checksums and the sentence length.
// Sentences reaching LINE_BUFFER_BYTES-1 characters are dropped silently.
// A byte taken from the input sits in the input register, is evaluated by the
// framer step into the result register and shows on the out_ ports from there;
// a stall of the result register can hold the byte in the input register.
// Throughput is one byte per cycle while in_stall stays low, set by the single
// framer step between the input and result registers.
// When the receiver stalls, the result register holds its beat; bytes that
// close no sentence keep flowing, and in_stall rises only when a byte that
// would give a new result finds the result register full and stalled.
// Synchronous reset (rst_n low) empties both registers and returns the
// framer to waiting for '$'.

module nmea_sentence_framer_checker_core #(
  parameter int LINE_BUFFER_BYTES = nmeachk_pkg::LINE_BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_frame_status,
  output logic [7:0] out_computed_sum,
  output logic [7:0] out_received_sum,
  output logic [6:0] out_sentence_length
);
  import nmeachk_pkg::*;

  logic          s1_valid_r, s1_valid_nxt;
  logic [7:0]    s1_byte_r, s1_byte_nxt;
  logic          out_valid_r, out_valid_nxt;
  frame_res_t    out_res_r;
  frame_res_t    step_res;
  logic          blocked;
  logic          step_en;

  // Held byte would produce a result while the result register is still full.
  assign blocked  = s1_valid_r && step_res.emit && out_valid_r && out_stall;
  assign step_en  = s1_valid_r && !blocked;
  assign in_stall = blocked;

  nmeachk_frame #(
    .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
  ) u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .rx_byte (s1_byte_r),
    .res     (step_res)
  );

  // Input register: reloads whenever the held byte moves on.
  always_comb begin
    s1_valid_nxt = blocked ? 1'b1 : in_valid;
    s1_byte_nxt  = blocked ? s1_byte_r : in_rx_byte;
  end

  // Result register: keeps its beat while stalled.
  assign out_valid_nxt = (step_en && step_res.emit) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_byte_r <= s1_byte_nxt;
    if (step_en && step_res.emit) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_frame_status    = out_res_r.status;
  assign out_computed_sum    = out_res_r.computed_sum;
  assign out_received_sum    = out_res_r.received_sum;
  assign out_sentence_length = out_res_r.sentence_length;

endmodule

### sv/nmeachk_checker.sv
// Port-level assertions for the NMEA sentence framer, bound to the top level.
// Depends on nmeachk_pkg and the defines header.
`timescale 1ns / 1ps
`include "nmea_sentence_framer_checker_core_defines.svh"

module nmeachk_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_frame_status,
  input logic [7:0] out_computed_sum,
  input logic [7:0] out_received_sum,
  input logic [6:0] out_sentence_length
);
  import nmeachk_pkg::*;

  // A stalled input beat stays put.
  `NMEACHK_ASSERT_NXT(a_in_hold, in_valid && in_stall,
    in_valid && $stable(in_rx_byte), "stalled input beat changed")

  // A stalled result beat stays put.
  `NMEACHK_ASSERT_NXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_frame_status) && $stable(out_computed_sum) &&
    $stable(out_received_sum) && $stable(out_sentence_length),
    "stalled result beat changed")

  // Status agrees with the two checksums when the digits were well formed.
  `NMEACHK_ASSERT_IMP(a_status_sum, out_valid && out_frame_status != FS_MALFORMED,
    (out_frame_status == FS_OK) == (out_computed_sum == out_received_sum),
    "status disagrees with the checksums")

  // Malformed beats carry a zero received checksum and no unused status code.
  `NMEACHK_ASSERT_IMP(a_malformed,
    out_valid && out_frame_status != FS_OK && out_frame_status != FS_MISMATCH,
    out_frame_status == FS_MALFORMED && out_received_sum == 8'h00,
    "bad malformed beat")

  // The shortest sentence is a dollar, a star and two checksum characters.
  `NMEACHK_ASSERT_IMP(a_min_len, out_valid, out_sentence_length >= 7'd4,
    "sentence shorter than four characters")

endmodule

bind nmea_sentence_framer_checker_core nmeachk_checker u_nmeachk_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .in_rx_byte          (in_rx_byte),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_frame_status    (out_frame_status),
  .out_computed_sum    (out_computed_sum),
  .out_received_sum    (out_received_sum),
  .out_sentence_length (out_sentence_length)
);
